>>> rtl/vsi_pkg.sv
// Shared types, widths and constants for the voxel span indexer.
`timescale 1ns / 1ps

package vsi_pkg;

	localparam int GRID_MAX = 64;
	localparam int MAX_SPAN = 4;

	localparam int COORD_W  = 32;
	localparam int INV_W    = 32;
	localparam int GRID_W   = 7;
	localparam int OFFSET_W = 19;
	localparam int INDEX_W  = 18;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	localparam int G_W    = $clog2(GRID_MAX + 1);
	localparam int GG_W   = $clog2(GRID_MAX * GRID_MAX + 1);
	localparam int TOT_W  = $clog2(GRID_MAX * GRID_MAX * GRID_MAX + 1);
	localparam int SPAN_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
	// flat index: |cell| <= 2^31, times N*N, plus a few smaller terms
	localparam int V_W    = COORD_W + GG_W + 2;

	localparam int MUL_A_W = COORD_W + 1;
	localparam int MUL_B_W = INV_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W - 1;

	localparam int S_DATA_W = 6 * COORD_W;
	localparam int M_DATA_W = ((INDEX_W + 2 + 7) / 8) * 8;

	localparam logic [INV_W-1:0]    INV_RESET    = INV_W'(65536);
	localparam logic [GRID_W-1:0]   GRID_RESET   = GRID_W'(16);
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV    = 2'd0,
		REG_GRID   = 2'd1,
		REG_OFFSET = 2'd2
	} reg_idx_t;

	// everything the voxel walker needs to emit one box
	typedef struct packed {
		logic signed [V_W-1:0] base;
		logic [G_W-1:0]        g;
		logic [GG_W-1:0]       gg;
		logic [TOT_W-1:0]      total;
		logic [SPAN_W-1:0]     lim_x;
		logic [SPAN_W-1:0]     lim_y;
		logic [SPAN_W-1:0]     lim_z;
		logic                  clip;
	} walk_cmd_t;

	// grid size register to the cells per axis actually used
	function automatic logic [G_W-1:0] grid_eff(input logic [GRID_W-1:0] grid);
		logic [GRID_W-1:0] t;
		begin
			if (grid == '0) begin
				t = GRID_W'(1);
			end else if (grid > GRID_W'(GRID_MAX)) begin
				t = GRID_W'(GRID_MAX);
			end else begin
				t = grid;
			end
			return t[G_W-1:0];
		end
	endfunction

endpackage

>>> rtl/vsi_cfg.sv
// Configuration registers of the voxel span indexer.
`timescale 1ns / 1ps

module vsi_cfg
	import vsi_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	output logic [INV_W-1:0]           inv,
	output logic [G_W-1:0]             g,
	output logic signed [OFFSET_W-1:0] offset
);

	logic [INV_W-1:0]    inv_q;
	logic [GRID_W-1:0]   grid_q;
	logic [OFFSET_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q    <= INV_RESET;
			grid_q   <= GRID_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INV:    inv_q    <= cfg_data[INV_W-1:0];
				REG_GRID:   grid_q   <= cfg_data[GRID_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign inv    = inv_q;
	assign g      = grid_eff(grid_q);
	assign offset = $signed(offset_q);

endmodule

>>> rtl/vsi_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
`timescale 1ns / 1ps

module vsi_mul
	import vsi_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0]        b,
	output logic signed [PROD_W-1:0]  prod
);

	logic signed [MUL_A_W+MUL_B_W:0] full;
	logic signed [PROD_W-1:0]        prod_q;

	assign full = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		prod_q <= full[PROD_W-1:0];
	end

	assign prod = prod_q;

endmodule

>>> rtl/vsi_walk.sv
// Voxel walker: steps through the covered cells and drives the output register.
`timescale 1ns / 1ps

module vsi_walk
	import vsi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  walk_cmd_t           cmd,
	output logic                busy,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast
);

	walk_cmd_t             cmd_q;
	logic                  busy_q;
	logic signed [V_W-1:0] v_q, vy_q, vx_q;
	logic [SPAN_W-1:0]     xd_q, yd_q, zd_q;
	logic                  m_tvalid_q;
	logic [INDEX_W-1:0]    index_q;
	logic                  oog_q, clip_q, last_q;

	logic                  advance, at_x, at_y, at_z, oog;
	logic signed [V_W-1:0] g_ext, gg_ext, tot_ext, vy_nx, vx_nx;

	assign advance = busy_q && (!m_tvalid_q || m_tready);
	assign at_x    = (xd_q == cmd_q.lim_x);
	assign at_y    = (yd_q == cmd_q.lim_y);
	assign at_z    = (zd_q == cmd_q.lim_z);
	assign g_ext   = $signed(V_W'(cmd_q.g));
	assign gg_ext  = $signed(V_W'(cmd_q.gg));
	assign tot_ext = $signed(V_W'(cmd_q.total));
	assign vy_nx   = vy_q + g_ext;
	assign vx_nx   = vx_q + gg_ext;
	assign oog     = (v_q < 0) || (v_q >= tot_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (advance && at_x && at_y && at_z) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
			v_q   <= cmd.base;
			vy_q  <= cmd.base;
			vx_q  <= cmd.base;
			xd_q  <= '0;
			yd_q  <= '0;
			zd_q  <= '0;
		end else if (advance) begin
			index_q <= v_q[INDEX_W-1:0];
			oog_q   <= oog;
			clip_q  <= cmd_q.clip;
			last_q  <= at_x && at_y && at_z;
			// z innermost, then y, then x
			priority if (!at_z) begin
				zd_q <= zd_q + 1'b1;
				v_q  <= v_q + V_W'(1);
			end else if (!at_y) begin
				yd_q <= yd_q + 1'b1;
				zd_q <= '0;
				vy_q <= vy_nx;
				v_q  <= vy_nx;
			end else if (!at_x) begin
				xd_q <= xd_q + 1'b1;
				yd_q <= '0;
				zd_q <= '0;
				vx_q <= vx_nx;
				vy_q <= vx_nx;
				v_q  <= vx_nx;
			end else begin
				zd_q <= zd_q;
			end
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({clip_q, oog_q, index_q});
	assign m_tlast  = last_q;

endmodule

>>> rtl/voxel_span_indexer.sv
// Top level of the voxel span indexer: box in, covered voxel indices out.
`timescale 1ns / 1ps
// The six coordinate scalings and four setup products share one 33x32 multiplier.
// A new box is taken only after the walker has loaded all V covered voxels of the
// last one into its output register (V from 1 to MAX_SPAN^3); indices leave one
// per cycle when the sink keeps up.
// Reset: arst_n clears the sequencer and output valid and loads the
// register defaults (reciprocal 1.0, 16 cells per axis, offset 0).

module voxel_span_indexer
	import vsi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// box input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
	// voxel output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // voxel_index, out_of_grid, span_clipped, pad
	output logic                 m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [2:0] step_q;

	// setup step codes
	localparam logic [2:0] SU_GG    = 3'd0;
	localparam logic [2:0] SU_YG    = 3'd1;
	localparam logic [2:0] SU_XGG   = 3'd2;
	localparam logic [2:0] SU_TOTAL = 3'd3;
	localparam logic [2:0] SU_START = 3'd4;
	localparam logic [2:0] CELL_LAST = 3'd6;

	logic [INV_W-1:0]           inv;
	logic [G_W-1:0]             g;
	logic signed [OFFSET_W-1:0] offset;

	logic signed [COORD_W-1:0] coord_q [6];
	logic signed [COORD_W-1:0] cell_q  [6];
	logic [GG_W-1:0]           gg_q;
	logic signed [V_W-1:0]     acc_q;
	logic [SPAN_W-1:0]         lim_q [3];
	logic                      clip_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]  prod;

	logic signed [COORD_W:0]   floor_c, cell_c;
	logic signed [V_W-1:0]     prod_v;
	logic signed [COORD_W:0]   span_d [3];
	logic [SPAN_W-1:0]         lim_c  [3];
	logic [2:0]                clip_c;

	walk_cmd_t cmd;
	logic      walk_start, walk_busy;

	vsi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.inv       (inv),
		.g         (g),
		.offset    (offset)
	);

	vsi_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign s_tready = (state_q == ST_IDLE);

	// Q32.32 product to cell, truncated toward zero
	assign floor_c = {prod[PROD_W-1], prod[PROD_W-1:32]};
	assign cell_c  = floor_c + (COORD_W+1)'(prod[PROD_W-1] && (prod[31:0] != '0));
	assign prod_v  = prod[V_W-1:0];

	// per-axis span of covered cells, clipped to MAX_SPAN
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			span_d[a] = {cell_q[a+3][COORD_W-1], cell_q[a+3]}
			          - {cell_q[a][COORD_W-1], cell_q[a]};
			clip_c[a] = (span_d[a] >= (COORD_W+1)'(MAX_SPAN));
			if (clip_c[a]) begin
				lim_c[a] = SPAN_W'(MAX_SPAN - 1);
			end else if (span_d[a] > 0) begin
				lim_c[a] = span_d[a][SPAN_W-1:0];
			end else begin
				lim_c[a] = '0;
			end
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CELL: begin
				if (step_q < CELL_LAST) begin
					mul_a = {coord_q[step_q][COORD_W-1], coord_q[step_q]};
				end
				mul_b = inv;
			end
			ST_SETUP: begin
				unique case (step_q)
					SU_GG: begin
						mul_a = MUL_A_W'(g);
						mul_b = MUL_B_W'(g);
					end
					SU_YG: begin
						mul_a = {cell_q[1][COORD_W-1], cell_q[1]};
						mul_b = MUL_B_W'(g);
					end
					SU_XGG: begin
						mul_a = {cell_q[0][COORD_W-1], cell_q[0]};
						mul_b = MUL_B_W'(gg_q);
					end
					SU_TOTAL: begin
						mul_a = MUL_A_W'(gg_q);
						mul_b = MUL_B_W'(g);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign walk_start = (state_q == ST_SETUP) && (step_q == SU_START);

	// N^3 leaves the multiplier in the start cycle and goes straight to the walker
	assign cmd.base  = acc_q;
	assign cmd.g     = g;
	assign cmd.gg    = gg_q;
	assign cmd.total = prod[TOT_W-1:0];
	assign cmd.lim_x = lim_q[0];
	assign cmd.lim_y = lim_q[1];
	assign cmd.lim_z = lim_q[2];
	assign cmd.clip  = clip_q;

	// sequencer: scale six coordinates, build base index, then hand off to walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_CELL;
					end
				end
				ST_CELL: begin
					if (step_q == CELL_LAST) begin
						state_q <= ST_SETUP;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SETUP: begin
					if (step_q == SU_START) begin
						state_q <= ST_EMIT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (!walk_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			for (int a = 0; a < 6; a++) begin
				coord_q[a] <= s_tdata[a*COORD_W +: COORD_W];
			end
		end
		if (state_q == ST_CELL && step_q != '0) begin
			cell_q[step_q - 1'b1] <= cell_c[COORD_W-1:0];
		end
		if (state_q == ST_SETUP) begin
			unique case (step_q)
				SU_YG: gg_q <= prod[GG_W-1:0];
				SU_XGG: begin
					// y*N + z + offset; x*N*N arrives next
					acc_q <= prod_v + V_W'(cell_q[2]) + V_W'(offset);
					for (int a = 0; a < 3; a++) begin
						lim_q[a] <= lim_c[a];
					end
					clip_q <= |clip_c;
				end
				SU_TOTAL: acc_q <= acc_q + prod_v;
				default: ;
			endcase
		end
	end

	vsi_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (walk_start),
		.cmd      (cmd),
		.busy     (walk_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
